// File: src/dcmas_pkg.sv
// Shared widths, scale constants and types for the dual-channel moving average scaler.
package dcmas_pkg;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned SCALED_W  = 13;
  localparam int unsigned DIV_W     = 23;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [SCALED_W-1:0] TEMP_SPAN  = 13'd5000;
  localparam logic [SCALED_W-1:0] LIGHT_SPAN = 13'd100;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 10'd1023;

  // floor(x / 1023) == (x * SCALE_RECIP) >> SCALE_SHIFT for every x below 2^23;
  // SCALE_RECIP is ceil(2^33 / 1023)
  localparam int unsigned SCALE_SHIFT = 33;
  localparam logic [23:0] SCALE_RECIP = 24'd8396809;

  localparam logic CH_TEMP  = 1'b0;
  localparam logic CH_LIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_DIVA,
    ST_MUL,
    ST_SCALE,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [SAMPLE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: src/dcmas_fifo.sv
// Two-entry queue between the front and back parts of the scaler.
module dcmas_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             valid_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o     = fill_q[1];
  assign valid_o    = (fill_q != 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

endmodule

// File: src/dcmas_front.sv
// Front part: accepts requests, tracks per-channel write position and fill state.
module dcmas_front #(
  parameter int unsigned WINDOW_LEN = 8,
  parameter int unsigned IDX_W      = $clog2(WINDOW_LEN),
  parameter int unsigned CNT_W      = $clog2(WINDOW_LEN + 1),
  parameter int unsigned ENTRY_W    = 1 + dcmas_pkg::SAMPLE_W + IDX_W + CNT_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_channel_i,
  input  logic [dcmas_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                          push_o,
  output logic [ENTRY_W-1:0]            push_data_o,
  input  logic                          queue_full_i
);

  logic [IDX_W-1:0] pos_q [2];
  logic [IDX_W-1:0] pos_d;
  logic             full_q [2];
  logic             full_d;
  logic             wrap;
  logic [CNT_W-1:0] count;
  logic             accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // Advance the selected channel's position; mark full on wrap
  always_comb begin
    wrap   = (pos_q[in_channel_i] == IDX_W'(WINDOW_LEN - 1));
    pos_d  = wrap ? '0 : pos_q[in_channel_i] + IDX_W'(1);
    full_d = full_q[in_channel_i] | wrap;
    count  = full_d ? CNT_W'(WINDOW_LEN) : CNT_W'(pos_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]  <= '0;
      pos_q[1]  <= '0;
      full_q[0] <= 1'b0;
      full_q[1] <= 1'b0;
    end else if (accept) begin
      pos_q[in_channel_i]  <= pos_d;
      full_q[in_channel_i] <= full_d;
    end
  end

  // Queue entry: channel, sample, write index, element count (low bit first)
  assign push_o      = accept;
  assign push_data_o = {count, pos_q[in_channel_i], in_sample_i, in_channel_i};

endmodule

// File: src/dcmas_div.sv
// Restoring divider, one quotient bit per cycle, used for the window mean.
module dcmas_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dcmas_pkg::div_req_t req_i,
  output dcmas_pkg::div_rsp_t rsp_o
);

  localparam int unsigned DW = dcmas_pkg::DIV_W;
  localparam int unsigned SW = dcmas_pkg::SAMPLE_W;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [dcmas_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SW-1:0]                   rem_q, rem_d;
  logic [SW-1:0]                   dvs_q;
  logic [DW-1:0]                   quo_q, quo_d;
  logic [SW:0]                     trial;
  logic                            ge;

  // One shift-subtract step
  always_comb begin
    trial  = {rem_q, quo_q[DW-1]};
    ge     = (trial >= {1'b0, dvs_q});
    rem_d  = ge ? SW'(trial - {1'b0, dvs_q}) : SW'(trial);
    quo_d  = {quo_q[DW-2:0], ge};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q - dcmas_pkg::DIV_CNT_W'(1);
      if (cnt_q == dcmas_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = dcmas_pkg::DIV_CNT_W'(DW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Load operands on start, shift while busy
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end else if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: src/dcmas_back.sv
// Back part: ring memory, serial window sum, mean, scaling and result register.
module dcmas_back #(
  parameter int unsigned WINDOW_LEN = 8,
  parameter int unsigned IDX_W      = $clog2(WINDOW_LEN),
  parameter int unsigned CNT_W      = $clog2(WINDOW_LEN + 1),
  parameter int unsigned ENTRY_W    = 1 + dcmas_pkg::SAMPLE_W + IDX_W + CNT_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           queue_valid_i,
  input  logic [ENTRY_W-1:0]             queue_data_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dcmas_pkg::SAMPLE_W-1:0] out_average_o,
  output logic [dcmas_pkg::SCALED_W-1:0] out_scaled_o,
  output logic                           out_channel_o
);

  localparam int unsigned SW         = dcmas_pkg::SAMPLE_W;
  localparam int unsigned SUM_W      = SW + CNT_W;
  localparam int unsigned ADDR_W     = IDX_W + 1;
  localparam int unsigned RING_DEPTH = 2 ** ADDR_W;
  localparam int unsigned RECIP_W    = $bits(dcmas_pkg::SCALE_RECIP);
  localparam int unsigned WIDE_W     = dcmas_pkg::DIV_W + RECIP_W;

  dcmas_pkg::back_state_e state_q, state_d;
  dcmas_pkg::div_req_t    div_req;
  dcmas_pkg::div_rsp_t    div_rsp;

  logic                        ch_q;
  logic [SW-1:0]               smp_q;
  logic [IDX_W-1:0]            widx_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [CNT_W-1:0]            issue_q;
  logic                        rd_vld_q;
  logic [SUM_W-1:0]            sum_q;
  logic [SW-1:0]               avg_q;
  logic [dcmas_pkg::DIV_W-1:0] prod_q;
  logic [dcmas_pkg::SCALED_W-1:0] span;
  logic [WIDE_W-1:0]           scl_wide;
  logic [dcmas_pkg::SCALED_W-1:0] scl_q;

  logic [SW-1:0]               ring_mem [RING_DEPTH];
  logic [SW-1:0]               rd_data_q;
  logic                        mem_we;
  logic                        rd_issue;
  logic                        sum_done;
  logic                        out_load;
  logic                        out_valid_q;
  logic [SW-1:0]               out_avg_q;
  logic [dcmas_pkg::SCALED_W-1:0] out_scl_q;
  logic                        out_ch_q;

  assign sum_done = (issue_q == cnt_q) && !rd_vld_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dcmas_pkg::ST_IDLE:  if (queue_valid_i) state_d = dcmas_pkg::ST_WRITE;
      dcmas_pkg::ST_WRITE: state_d = dcmas_pkg::ST_SUM;
      dcmas_pkg::ST_SUM:   if (sum_done) state_d = dcmas_pkg::ST_DIVA;
      dcmas_pkg::ST_DIVA:  if (div_rsp.done) state_d = dcmas_pkg::ST_MUL;
      dcmas_pkg::ST_MUL:   state_d = dcmas_pkg::ST_SCALE;
      dcmas_pkg::ST_SCALE: state_d = dcmas_pkg::ST_DONE;
      dcmas_pkg::ST_DONE:  if (!out_valid_q || out_ready_i) state_d = dcmas_pkg::ST_IDLE;
      default:             state_d = dcmas_pkg::ST_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    pop_o            = (state_q == dcmas_pkg::ST_IDLE) && queue_valid_i;
    mem_we           = (state_q == dcmas_pkg::ST_WRITE);
    rd_issue         = (state_q == dcmas_pkg::ST_SUM) && (issue_q != cnt_q);
    out_load         = (state_q == dcmas_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
    div_req.start    = (state_q == dcmas_pkg::ST_SUM) && sum_done;
    div_req.dividend = dcmas_pkg::DIV_W'(sum_q);
    div_req.divisor  = SW'(cnt_q);
    span             = (ch_q == dcmas_pkg::CH_LIGHT) ? dcmas_pkg::LIGHT_SPAN
                                                     : dcmas_pkg::TEMP_SPAN;
  end

  // Divide the scaled product by full scale through a reciprocal multiply
  assign scl_wide = WIDE_W'(prod_q) * WIDE_W'(dcmas_pkg::SCALE_RECIP);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcmas_pkg::ST_IDLE;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        issue_q  <= '0;
        rd_vld_q <= 1'b0;
      end else if (state_q == dcmas_pkg::ST_SUM) begin
        rd_vld_q <= rd_issue;
        if (rd_issue) begin
          issue_q <= issue_q + CNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[{ch_q, widx_q}] <= smp_q;
    end
    rd_data_q <= ring_mem[{ch_q, issue_q[IDX_W-1:0]}];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      {cnt_q, widx_q, smp_q, ch_q} <= queue_data_i;
    end
    if (mem_we) begin
      sum_q <= '0;
    end else if ((state_q == dcmas_pkg::ST_SUM) && rd_vld_q) begin
      sum_q <= sum_q + SUM_W'(rd_data_q);
    end
    if ((state_q == dcmas_pkg::ST_DIVA) && div_rsp.done) begin
      avg_q <= div_rsp.quotient[SW-1:0];
    end
    if (state_q == dcmas_pkg::ST_MUL) begin
      prod_q <= avg_q * span;
    end
    if (state_q == dcmas_pkg::ST_SCALE) begin
      scl_q <= scl_wide[dcmas_pkg::SCALE_SHIFT +: dcmas_pkg::SCALED_W];
    end
    if (out_load) begin
      out_avg_q <= avg_q;
      out_scl_q <= scl_q;
      out_ch_q  <= ch_q;
    end
  end

  dcmas_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o   = out_valid_q;
  assign out_average_o = out_avg_q;
  assign out_scaled_o  = out_scl_q;
  assign out_channel_o = out_ch_q;

endmodule

// File: src/dual_channel_moving_average_scaler.sv
// Top level of the dual-channel moving average scaler.
// Each request selects the temperature (tuser 0) or light (tuser 1) channel and carries a
// 10-bit converter sample. The sample enters that channel's ring of the last WINDOW_LEN
// samples; the result is the truncated mean of the samples stored so far (all WINDOW_LEN
// once the ring has wrapped) and that mean scaled by 5000/1023 (temperature, tenths of a
// degree) or 100/1023 (light, percent). One result per request, in order. For each request
// the window is summed one ring entry per cycle through the ring memory's single read port,
// the mean takes 23 steps of a bit-serial divider, and the scaling is a multiply by the span
// followed by a multiply by a fixed reciprocal of 1023. A two-entry queue lets up to two
// requests wait while one is processed, and a result register lets a finished result wait
// for tready. No clearing pass is needed after reset.
module dual_channel_moving_average_scaler #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [9:0] sample, [15:10] zero
  input  logic        s_axis_tuser_i,   // [0] channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [9:0] average, [22:10] scaled_value, [23] zero
  output logic        m_axis_tuser_o    // [0] channel_out
);

  localparam int unsigned IDX_W   = $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int unsigned ENTRY_W = 1 + dcmas_pkg::SAMPLE_W + IDX_W + CNT_W;

  logic                           push;
  logic [ENTRY_W-1:0]             push_data;
  logic                           queue_full;
  logic                           pop;
  logic [ENTRY_W-1:0]             pop_data;
  logic                           queue_valid;
  logic [dcmas_pkg::SAMPLE_W-1:0] average;
  logic [dcmas_pkg::SCALED_W-1:0] scaled;

  dcmas_front #(
    .WINDOW_LEN (WINDOW_LEN),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_channel_i (s_axis_tuser_i),
    .in_sample_i  (s_axis_tdata_i[dcmas_pkg::SAMPLE_W-1:0]),
    .push_o       (push),
    .push_data_o  (push_data),
    .queue_full_i (queue_full)
  );

  dcmas_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (queue_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .valid_o     (queue_valid)
  );

  dcmas_back #(
    .WINDOW_LEN (WINDOW_LEN),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (queue_valid),
    .queue_data_i  (pop_data),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_average_o (average),
    .out_scaled_o  (scaled),
    .out_channel_o (m_axis_tuser_o)
  );

  // Pack the result fields, zero fill to whole bytes
  assign m_axis_tdata_o = {1'b0, scaled, average};

endmodule
